// ----- sv/vcs_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// vcs_pkg
// Types, constants and fixed-point helpers for the vertex clip setup block.
// ============================================================================
package vcs_pkg;

    localparam int GAMMA_ENTRIES   = 256;
    localparam int QUOT_BITS       = 32;
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = QUOT_BITS / STEPS_PER_STAGE;

    localparam logic signed [31:0] Q_ONE    = 32'sd65536;
    localparam logic signed [31:0] SAT_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN  = 32'sh8000_0000;
    localparam logic [32:0]        QMAG_OVF = 33'h1_0000_0000;

    // depth_flags bit positions
    localparam int DF_NEAR       = 0;
    localparam int DF_FAR        = 1;
    localparam int DF_KEEP_ALPHA = 2;

    typedef enum logic [2:0] {
        MODE_GOURAUD_TEX = 3'd0,
        MODE_GOURAUD     = 3'd1,
        MODE_THERMAL     = 3'd2,
        MODE_CLOAKED     = 3'd3,
        MODE_SKY         = 3'd4,
        MODE_DECAL       = 3'd5,
        MODE_PARTICLE    = 3'd6,
        MODE_OTHER       = 3'd7
    } vmode_t;

    typedef enum logic [2:0] {
        CFG_VERTEX_MODE = 3'd0,
        CFG_DEPTH_FLAGS = 3'd1,
        CFG_X_SCALE     = 3'd2,
        CFG_Y_SCALE     = 3'd3,
        CFG_NEAR_PLANE  = 3'd4,
        CFG_HUD_OFFSET  = 3'd5,
        CFG_TEX_SCALE   = 3'd6,
        CFG_FIXED_COLOR = 3'd7
    } cfg_reg_t;

    localparam logic CMD_GAMMA_WRITE = 1'b0;
    localparam logic CMD_VERTEX      = 1'b1;

    typedef struct packed {
        logic               command;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] tex_u;
        logic signed [31:0] tex_v;
        logic [31:0]        vertex_color;
        logic [23:0]        specular_color;
        logic [7:0]         gamma_index;
        logic [7:0]         gamma_value;
    } vcs_in_t;

    typedef struct packed {
        logic signed [31:0] clip_x;
        logic signed [31:0] clip_y;
        logic signed [31:0] clip_z;
        logic signed [31:0] clip_w;
        logic signed [31:0] tex_s;
        logic signed [31:0] tex_t;
        logic [31:0]        out_color;
        logic [31:0]        out_specular;
    } vcs_out_t;

    typedef struct packed {
        logic [32:0] rem;
        logic [31:0] word;
    } div_state_t;

    // Saturate a 65-bit signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat65(input logic signed [64:0] v);
        logic signed [31:0] r;
        if (v > 65'sh0_7FFF_FFFF)
            r = SAT_MAX;
        else if (v < -65'sh0_8000_0000)
            r = SAT_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

    // One restoring-division step: next quotient bit shifts into word.
    function automatic div_state_t div_step(input div_state_t s, input logic [32:0] dmag);
        logic [33:0] r2;
        div_state_t  o;
        r2 = {s.rem, s.word[31]};
        if (r2 >= {1'b0, dmag})
        begin
            o.rem  = 33'(r2 - {1'b0, dmag});
            o.word = {s.word[30:0], 1'b1};
        end
        else
        begin
            o.rem  = r2[32:0];
            o.word = {s.word[30:0], 1'b0};
        end
        return o;
    endfunction

endpackage

// ----- sv/vertex_clip_setup_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// vertex_clip_setup_top
// View-space vertex to clip-space vertex, Q16.16, with gamma-mapped color.
// ============================================================================
// One transaction per clock in steady state on both channels while out_ready
// is held high. The datapath is a 22-register pipeline built around the depth
// divider (32 quotient bits, two restoring steps per stage, 16 stages), with
// capture, multiply and saturate stages around it. Each stage has its own
// valid bit and holds while it is full and the stage after it cannot load,
// so bubbles collapse and a stalled output only backs up the pipeline as far
// as it is full. Gamma-write transactions update the 256-entry table in order
// with vertices and produce no output. The table powers up undefined; program
// every entry used before running gouraud textured mode. Configuration writes
// are applied immediately and must only happen while the pipeline is empty.
module vertex_clip_setup_top
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_index,
    input  logic [31:0]     cfg_data,
    input  logic            in_valid,
    output logic            in_ready,
    input  vcs_pkg::vcs_in_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output vcs_pkg::vcs_out_t out_data
);
    import vcs_pkg::*;

    localparam int ST_IN      = 0;
    localparam int ST_FETCH   = 1;
    localparam int ST_DIV0    = 2;
    localparam int ST_POST    = ST_DIV0 + DIV_STAGES + 1;
    localparam int ST_MUL     = ST_POST + 1;
    localparam int ST_OUT     = ST_MUL + 1;
    localparam int NUM_STAGES = ST_OUT + 1;

    // Fields carried alongside the divider.
    typedef struct packed {
        logic signed [31:0] clip_x;
        logic signed [31:0] clip_y;
        logic signed [31:0] clip_w;
        logic signed [31:0] z_alt;
        logic               use_div;
        logic signed [31:0] tex_s;
        logic signed [31:0] tex_t;
        logic [31:0]        color;
        logic [31:0]        spec;
    } side_t;

    typedef struct packed {
        logic signed [31:0] w;
        logic signed [63:0] px_p;
        logic signed [63:0] py_p;
        logic signed [48:0] u_p;
        logic signed [48:0] v_p;
        logic [32:0]        dmag;
        logic               dneg;
        logic               dzero;
        logic [48:0]        nmag;
        logic               nneg;
        logic               npos;
        logic [31:0]        vc;
    } fetch_t;

    typedef struct packed {
        side_t       side;
        div_state_t  dv;
        logic [32:0] dmag;
        logic        ovf;
        logic        neg;
        logic        dzero;
        logic        npos;
        logic        nneg;
    } mid_t;

    typedef struct packed {
        side_t              side;
        logic signed [31:0] f;
    } post_t;

    typedef struct packed {
        side_t              side;
        logic signed [63:0] prod;
    } mul_t;

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    vmode_t             mode_reg;
    logic [2:0]         flags_reg;
    logic signed [31:0] x_scale_reg;
    logic signed [31:0] y_scale_reg;
    logic signed [31:0] near_reg;
    logic signed [31:0] hud_reg;
    logic [31:0]        tex_scale_reg;
    logic [31:0]        fixed_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_GOURAUD_TEX;
            flags_reg       <= '0;
            x_scale_reg     <= Q_ONE;
            y_scale_reg     <= Q_ONE;
            near_reg        <= '0;
            hud_reg         <= '0;
            tex_scale_reg   <= '0;
            fixed_color_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_VERTEX_MODE: mode_reg        <= vmode_t'(cfg_data[2:0]);
                CFG_DEPTH_FLAGS: flags_reg       <= cfg_data[2:0];
                CFG_X_SCALE:     x_scale_reg     <= cfg_data;
                CFG_Y_SCALE:     y_scale_reg     <= cfg_data;
                CFG_NEAR_PLANE:  near_reg        <= cfg_data;
                CFG_HUD_OFFSET:  hud_reg         <= cfg_data;
                CFG_TEX_SCALE:   tex_scale_reg   <= cfg_data;
                CFG_FIXED_COLOR: fixed_color_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Stage valids and per-stage advance. A stage loads when it is empty or
    // the stage after it is loading.
    // ---------------------------------------------------------------------
    logic                  vld_reg [NUM_STAGES];
    logic [NUM_STAGES:0]   en;

    always_comb
    begin
        en[NUM_STAGES] = out_ready;
        for (int i = NUM_STAGES - 1; i >= 0; i--)
            en[i] = !vld_reg[i] || en[i + 1];
    end

    assign in_ready  = en[ST_IN];
    assign out_valid = vld_reg[ST_OUT];

    vcs_in_t in_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STAGES; i++)
                vld_reg[i] <= 1'b0;
        end
        else
        begin
            if (en[ST_IN])
                vld_reg[ST_IN] <= in_valid;
            // gamma writes retire here and never reach the output
            if (en[ST_FETCH])
                vld_reg[ST_FETCH] <= vld_reg[ST_IN] && (in_reg.command == CMD_VERTEX);
            for (int i = ST_DIV0; i < NUM_STAGES; i++)
                if (en[i])
                    vld_reg[i] <= vld_reg[i - 1];
        end
    end

    // ---------------------------------------------------------------------
    // Stage 0: input capture
    // ---------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (en[ST_IN])
            in_reg <= in_data;
    end

    // ---------------------------------------------------------------------
    // Gamma table: three identical copies, two reads each, six lookups per
    // vertex. Written and read at the stage 0 to stage 1 transfer, so table
    // updates stay in order with vertices.
    // ---------------------------------------------------------------------
    logic [7:0] gamma_a [GAMMA_ENTRIES];
    logic [7:0] gamma_b [GAMMA_ENTRIES];
    logic [7:0] gamma_c [GAMMA_ENTRIES];
    logic [7:0] g_rd_reg [6];
    logic       g_wr;

    assign g_wr = en[ST_FETCH] && vld_reg[ST_IN] && (in_reg.command == CMD_GAMMA_WRITE);

    always_ff @(posedge clk)
    begin
        if (g_wr)
        begin
            gamma_a[in_reg.gamma_index] <= in_reg.gamma_value;
            gamma_b[in_reg.gamma_index] <= in_reg.gamma_value;
            gamma_c[in_reg.gamma_index] <= in_reg.gamma_value;
        end
        if (en[ST_FETCH])
        begin
            g_rd_reg[0] <= gamma_a[in_reg.vertex_color[7:0]];
            g_rd_reg[1] <= gamma_a[in_reg.vertex_color[15:8]];
            g_rd_reg[2] <= gamma_b[in_reg.vertex_color[23:16]];
            g_rd_reg[3] <= gamma_b[in_reg.specular_color[7:0]];
            g_rd_reg[4] <= gamma_c[in_reg.specular_color[15:8]];
            g_rd_reg[5] <= gamma_c[in_reg.specular_color[23:16]];
        end
    end

    // ---------------------------------------------------------------------
    // Stage 1: products, w, divisor and dividend magnitudes
    // ---------------------------------------------------------------------
    fetch_t             fetch_reg;
    fetch_t             fetch_next;
    logic signed [33:0] d_wide;
    logic [31:0]        n_abs;

    always_comb
    begin
        fetch_next.w    = sat65(65'(in_reg.pos_z) <<< 16);
        fetch_next.px_p = in_reg.pos_x * x_scale_reg;
        fetch_next.py_p = in_reg.pos_y * y_scale_reg;
        fetch_next.u_p  = 49'(in_reg.tex_u) * $signed({1'b0, tex_scale_reg[15:0]});
        fetch_next.v_p  = 49'(in_reg.tex_v) * $signed({1'b0, tex_scale_reg[31:16]});
        d_wide          = 34'(fetch_next.w) + 34'(hud_reg);
        fetch_next.dneg = d_wide[33];
        fetch_next.dmag = d_wide[33] ? 33'(-d_wide) : d_wide[32:0];
        fetch_next.dzero = (d_wide == '0);
        n_abs           = near_reg[31] ? 32'(-near_reg) : near_reg;
        // 2 * N * 65536 as a magnitude
        fetch_next.nmag = {n_abs, 17'b0};
        fetch_next.nneg = near_reg[31];
        fetch_next.npos = !near_reg[31] && (near_reg != '0);
        fetch_next.vc   = in_reg.vertex_color;
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_FETCH])
            fetch_reg <= fetch_next;
    end

    // ---------------------------------------------------------------------
    // Stage 2: saturation, color, non-divide depth, divider setup
    // ---------------------------------------------------------------------
    mid_t               mid_reg [DIV_STAGES + 1];
    mid_t               mid0_next;
    logic signed [64:0] wx;
    logic signed [31:0] z_near;
    logic signed [31:0] z_far;
    logic signed [31:0] z_sub;
    logic               textured;

    always_comb
    begin
        mid0_next.side.clip_x = sat65(65'(fetch_reg.px_p));
        mid0_next.side.clip_y = sat65(-65'(fetch_reg.py_p));
        mid0_next.side.clip_w = fetch_reg.w;

        // 65535 * W without a multiplier
        wx     = (65'(fetch_reg.w) <<< 16) - 65'(fetch_reg.w);
        z_near = sat65((-wx) >>> 16);
        z_far  = sat65(wx >>> 16);
        z_sub  = sat65(65'(fetch_reg.w) - (65'(near_reg) <<< 1));

        mid0_next.side.use_div = 1'b1;
        mid0_next.side.z_alt   = fetch_reg.w;
        if (mode_reg == MODE_SKY)
            mid0_next.side.use_div = 1'b0;
        else if (mode_reg == MODE_PARTICLE)
        begin
            mid0_next.side.use_div = 1'b0;
            if (flags_reg[DF_NEAR])
                mid0_next.side.z_alt = z_near;
            else if (flags_reg[DF_FAR])
                mid0_next.side.z_alt = z_far;
            else
                mid0_next.side.z_alt = z_sub;
        end

        textured = (mode_reg inside {MODE_GOURAUD_TEX, MODE_CLOAKED, MODE_SKY,
                                     MODE_DECAL, MODE_PARTICLE});
        mid0_next.side.tex_s = textured ? sat65(65'(fetch_reg.u_p)) : '0;
        mid0_next.side.tex_t = textured ? sat65(65'(fetch_reg.v_p)) : '0;

        mid0_next.side.spec = '0;
        case (mode_reg)
            MODE_GOURAUD_TEX:
            begin
                mid0_next.side.color = {fetch_reg.vc[31:24], g_rd_reg[2], g_rd_reg[1],
                                        g_rd_reg[0]};
                mid0_next.side.spec  = {fetch_reg.vc[31:24], g_rd_reg[5], g_rd_reg[4],
                                        g_rd_reg[3]};
            end
            MODE_GOURAUD:
                mid0_next.side.color = flags_reg[DF_KEEP_ALPHA] ? fetch_reg.vc
                                     : {8'hFF, fetch_reg.vc[23:0]};
            MODE_THERMAL, MODE_CLOAKED, MODE_SKY:
                mid0_next.side.color = fetch_reg.vc;
            MODE_DECAL, MODE_PARTICLE:
                mid0_next.side.color = fixed_color_reg;
            default:
                mid0_next.side.color = '0;
        endcase

        // quotient above 32 bits means saturation
        mid0_next.ovf      = ({16'b0, fetch_reg.nmag[48:32]} >= fetch_reg.dmag);
        mid0_next.dv.rem   = {16'b0, fetch_reg.nmag[48:32]};
        mid0_next.dv.word  = fetch_reg.nmag[31:0];
        mid0_next.dmag     = fetch_reg.dmag;
        mid0_next.neg      = fetch_reg.nneg ^ fetch_reg.dneg;
        mid0_next.dzero    = fetch_reg.dzero;
        mid0_next.npos     = fetch_reg.npos;
        mid0_next.nneg     = fetch_reg.nneg;
    end

    // ---------------------------------------------------------------------
    // Stages 3..18: restoring divider, two quotient bits per stage
    // ---------------------------------------------------------------------
    mid_t mid_next [DIV_STAGES + 1];

    always_comb
    begin
        mid_next[0] = mid0_next;
        for (int k = 1; k <= DIV_STAGES; k++)
        begin
            mid_next[k] = mid_reg[k - 1];
            for (int j = 0; j < STEPS_PER_STAGE; j++)
                mid_next[k].dv = div_step(mid_next[k].dv, mid_reg[k - 1].dmag);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= DIV_STAGES; k++)
            if (en[ST_DIV0 + k])
                mid_reg[k] <= mid_next[k];
    end

    // ---------------------------------------------------------------------
    // Stage 19: signed quotient, zero divisor, f = 1 - q
    // ---------------------------------------------------------------------
    post_t              post_reg;
    post_t              post_next;
    logic [32:0]        qmag;
    logic signed [64:0] qx;
    logic signed [31:0] q;

    always_comb
    begin
        qmag = mid_reg[DIV_STAGES].ovf ? QMAG_OVF : {1'b0, mid_reg[DIV_STAGES].dv.word};
        qx   = $signed({32'b0, qmag});
        q    = sat65(mid_reg[DIV_STAGES].neg ? -qx : qx);
        if (mid_reg[DIV_STAGES].dzero)
        begin
            if (mid_reg[DIV_STAGES].npos)
                q = SAT_MAX;
            else if (mid_reg[DIV_STAGES].nneg)
                q = SAT_MIN;
            else
                q = '0;
        end
        post_next.side = mid_reg[DIV_STAGES].side;
        post_next.f    = sat65(65'(Q_ONE) - 65'(q));
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_POST])
            post_reg <= post_next;
    end

    // ---------------------------------------------------------------------
    // Stage 20: W * f
    // ---------------------------------------------------------------------
    mul_t mul_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_MUL])
        begin
            mul_reg.side <= post_reg.side;
            mul_reg.prod <= post_reg.side.clip_w * post_reg.f;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 21: output register
    // ---------------------------------------------------------------------
    vcs_out_t out_reg;
    vcs_out_t out_next;

    always_comb
    begin
        out_next.clip_x       = mul_reg.side.clip_x;
        out_next.clip_y       = mul_reg.side.clip_y;
        out_next.clip_z       = mul_reg.side.use_div ? sat65(65'(mul_reg.prod) >>> 16)
                              : mul_reg.side.z_alt;
        out_next.clip_w       = mul_reg.side.clip_w;
        out_next.tex_s        = mul_reg.side.tex_s;
        out_next.tex_t        = mul_reg.side.tex_t;
        out_next.out_color    = mul_reg.side.color;
        out_next.out_specular = mul_reg.side.spec;
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
            out_reg <= out_next;
    end

    assign out_data = out_reg;

`ifndef SYNTHESIS
    // a gamma write never advances into the vertex datapath
    a_gamma_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_IN] && en[ST_FETCH] && (in_reg.command == CMD_GAMMA_WRITE)
        |=> !vld_reg[ST_FETCH])
        else $error("gamma write entered datapath");

    // an empty output stage lets the whole pipeline move
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[ST_OUT] |-> in_ready)
        else $error("pipeline stalled with empty output stage");

    // zero divisor always flags overflow in the divider setup
    a_zero_div_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_DIV0] && mid_reg[0].dzero |-> mid_reg[0].ovf)
        else $error("zero divisor without overflow flag");

    // a stalled output stage keeps its result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_reg))
        else $error("output result lost while stalled");
`endif

endmodule
